[hdl/ptlru_pkg.sv]
// Package: shared types, constants and codes for the LRU page table translator.
`default_nettype none
package ptlru_pkg;
    localparam int VIRTUAL_PAGES   = 64;
    localparam int PHYS_FRAMES     = 32;
    localparam int MAX_OFFSET_BITS = 12;

    localparam int VPN_W   = 6;
    localparam int OFF_W   = 12;
    localparam int STAMP_W = 31;
    localparam int FRAME_W = 5;
    localparam int FCNT_W  = 6;
    localparam int PA_W    = 17;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_VPC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PFC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBC = 2'd2;

    typedef struct packed {
        logic [VPN_W-1:0]   virtual_page;
        logic [OFF_W-1:0]   byte_offset;
        logic [STAMP_W-1:0] time_stamp;
        logic               is_store;
    } t_in;

    typedef struct packed {
        logic [PA_W-1:0]    phys_addr;
        logic               page_fault;
        logic               replaced;
        logic [VPN_W-1:0]   victim_page;
        logic [FRAME_W-1:0] victim_frame;
        logic               victim_dirty;
        logic [FCNT_W-1:0]  frames_in_use;
        logic               bad_page;
    } t_out;

    // classified request handed from front to back
    typedef struct packed {
        t_in  req;
        logic bad;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOK, ST_SCAN, ST_EVICT, ST_WRITE, ST_EMIT
    } t_state;
endpackage
`default_nettype wire

[hdl/ptlru_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module ptlru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hdl/ptlru_front.sv]
// Front end: takes requests, checks the page bound, queues commands.
`default_nettype none
module ptlru_front #(
    parameter int VPAGES = ptlru_pkg::VIRTUAL_PAGES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire ptlru_pkg::t_in    i_data,
    input  wire logic [ptlru_pkg::CFG_W-1:0] i_vpc,
    output logic                   o_cmd_valid,
    output ptlru_pkg::t_cmd        o_cmd,
    input  wire logic              i_cmd_pop
);
    import ptlru_pkg::*;
    localparam int VPW = $clog2(VPAGES + 1);
    localparam int QD = 2;

    t_cmd       r_q [QD];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic [VPW-1:0] lim;
    t_cmd       c;

    always_comb begin
        lim = (32'(i_vpc) > VPAGES) ? VPW'(VPAGES) : VPW'(i_vpc);
        c.req = i_data;
        c.bad = (32'(i_data.virtual_page) >= 32'(lim));
    end

    assign o_stall     = (r_cnt == 2'(QD));
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= c;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop);
        end
    end
endmodule
`default_nettype wire

[hdl/ptlru_back.sv]
// Back end: table lookup, LRU scan, update and result register.
`default_nettype none
module ptlru_back #(
    parameter int VPAGES = ptlru_pkg::VIRTUAL_PAGES,
    parameter int PFRAMES = ptlru_pkg::PHYS_FRAMES,
    parameter int MAXOFF = ptlru_pkg::MAX_OFFSET_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_valid,
    input  wire ptlru_pkg::t_cmd   i_cmd,
    output logic                   o_cmd_pop,
    input  wire logic [5:0]        i_pfc,
    input  wire logic [3:0]        i_obc,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output ptlru_pkg::t_out        o_data
);
    import ptlru_pkg::*;
    localparam int AW = $clog2(VPAGES);
    localparam int SW = AW + 1;
    localparam int EW = FRAME_W + STAMP_W; // frame, stamp

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [VPAGES-1:0] r_valid, r_dirty;
    logic [FCNT_W-1:0] r_used;
    logic [AW:0]       r_scan;          // scan address issued
    logic              r_scan_v;        // read data in flight
    logic [AW-1:0]     r_scan_a;
    logic              r_found;
    logic [AW-1:0]     r_best;
    logic [STAMP_W-1:0] r_best_ts;
    logic [FRAME_W-1:0] r_best_fr;
    logic [FRAME_W-1:0] r_frame;
    t_out  r_res, n_res;    // result being built
    t_out  r_out, n_out;    // result on the output
    logic  r_ov;

    logic          we;
    logic          emit;
    logic [AW-1:0] raddr;
    logic [EW-1:0] rdata;
    logic [FCNT_W-1:0] ppc;
    logic [3:0]    sh;
    logic [AW-1:0] p;

    assign p = AW'(r_cmd.req.virtual_page);
    assign ppc = (i_pfc > 6'(PFRAMES)) ? 6'(PFRAMES) : ((i_pfc == 6'd0) ? 6'd1 : i_pfc);
    assign sh  = (i_obc > 4'(MAXOFF)) ? 4'(MAXOFF) : i_obc;

    ptlru_ram #(.WIDTH(EW), .DEPTH(VPAGES)) u_tab (
        .i_clk(i_clk), .i_we(we), .i_waddr(p),
        .i_wdata({r_frame, r_cmd.req.time_stamp}),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        we        = 1'b0;
        emit      = 1'b0;
        raddr     = p;
        n_res     = r_res;
        unique case (r_state)
            ST_IDLE: begin
                // read the waiting command's entry so a hit has its frame in LOOK
                raddr = AW'(i_cmd.req.virtual_page);
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_state   = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_res = '0;
                n_res.bad_page = r_cmd.bad;
                n_res.page_fault = !r_cmd.bad && !r_valid[p];
                if (r_cmd.bad) n_state = ST_EMIT;
                else if (r_valid[p] || r_used < ppc) n_state = ST_WRITE;
                else n_state = ST_SCAN;
            end
            ST_SCAN: begin
                raddr = r_scan[AW-1:0];
                if (r_scan[AW] && !r_scan_v) n_state = ST_EVICT;
            end
            ST_EVICT: begin
                n_state = ST_WRITE;
                if (r_found) begin
                    n_res.replaced = 1'b1;
                    n_res.victim_page = VPN_W'(r_best);
                    n_res.victim_frame = r_best_fr;
                    n_res.victim_dirty = r_dirty[r_best];
                end
            end
            ST_WRITE: begin
                we = 1'b1;
                n_state = ST_EMIT;
            end
            // wait while the previous result is still held
            ST_EMIT: if (!r_ov || !i_stall) begin
                emit = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        n_out = r_res;
        n_out.phys_addr = r_cmd.bad ? '0
                        : PA_W'((32'(r_frame) << sh) | 32'(r_cmd.req.byte_offset));
        n_out.frames_in_use = r_used;
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) r_cmd <= i_cmd;
        r_res <= n_res;
        if (emit) r_out <= n_out;
        case (r_state)
            ST_LOOK: begin
                r_scan <= '0; r_scan_v <= 1'b0; r_found <= 1'b0;
                if (!r_cmd.bad) begin
                    // hit: stored frame; miss: next unused frame
                    if (r_valid[p]) r_frame <= rdata[EW-1:STAMP_W];
                    else r_frame <= FRAME_W'(r_used);
                end
            end
            ST_SCAN: begin
                r_scan_v <= !r_scan[AW];
                r_scan_a <= r_scan[AW-1:0];
                if (!r_scan[AW]) r_scan <= r_scan + SW'(1);
                if (r_scan_v && r_valid[r_scan_a] &&
                    (!r_found || rdata[STAMP_W-1:0] < r_best_ts)) begin
                    r_found <= 1'b1; r_best <= r_scan_a;
                    r_best_ts <= rdata[STAMP_W-1:0];
                    r_best_fr <= rdata[EW-1:STAMP_W];
                end
            end
            ST_EVICT: if (r_found) r_frame <= r_best_fr;
            default: ;
        endcase

        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_valid <= '0; r_dirty <= '0;
            r_used <= '0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            if (r_state == ST_EVICT && r_found) begin
                r_valid[r_best] <= 1'b0; r_dirty[r_best] <= 1'b0;
            end
            if (r_state == ST_WRITE) begin
                r_valid[p] <= 1'b1;
                if (r_res.page_fault) r_dirty[p] <= r_cmd.req.is_store;
                else if (r_cmd.req.is_store) r_dirty[p] <= 1'b1;
                if (r_res.page_fault && !r_res.replaced) r_used <= r_used + FCNT_W'(1);
            end
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;
endmodule
`default_nettype wire

[hdl/page_table_lru_translate.sv]
// Top level of the LRU page table translator.
// With the back end idle, a transfer in passes through pop with table read,
// lookup, table write and result load before it shows up in the result
// register. A hit or an allocation holds the back end through those steps,
// and it pops no new command until it has loaded the last result. A fault
// with every frame in use also scans the whole table through its single read
// port, between lookup and table write. A two-entry command queue lets
// requests arrive while the back end works; the result register holds one
// transfer while the consumer stalls, and the back end waits to load the next result until that one is taken.
`default_nettype none
module page_table_lru_translate #(
    parameter int VIRTUAL_PAGES   = ptlru_pkg::VIRTUAL_PAGES,
    parameter int PHYS_FRAMES     = ptlru_pkg::PHYS_FRAMES,
    parameter int MAX_OFFSET_BITS = ptlru_pkg::MAX_OFFSET_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire ptlru_pkg::t_in                      i_data,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output ptlru_pkg::t_out                          o_data,
    input  wire logic                                i_cfg_we,
    input  wire logic [ptlru_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ptlru_pkg::CFG_W-1:0]         i_cfg_data
);
    import ptlru_pkg::*;
    logic [6:0] r_vpc;
    logic [5:0] r_pfc;
    logic [3:0] r_obc;
    logic cmd_valid, cmd_pop;
    t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpc <= 7'd64; r_pfc <= 6'd32; r_obc <= 4'd12;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VPC: r_vpc <= i_cfg_data;
                CFG_PFC: r_pfc <= i_cfg_data[5:0];
                CFG_OBC: r_obc <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    ptlru_front #(.VPAGES(VIRTUAL_PAGES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .i_vpc(r_vpc), .o_cmd_valid(cmd_valid), .o_cmd(cmd),
        .i_cmd_pop(cmd_pop)
    );

    ptlru_back #(.VPAGES(VIRTUAL_PAGES), .PFRAMES(PHYS_FRAMES),
                 .MAXOFF(MAX_OFFSET_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_pop(cmd_pop), .i_pfc(r_pfc), .i_obc(r_obc),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );
endmodule
`default_nettype wire

[hdl/ptlru_check.sv]
// Port-level checker for the translator, bound to the top level.
`default_nettype none
module ptlru_check (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            o_valid,
    input wire logic            i_stall,
    input wire ptlru_pkg::t_out o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("result dropped");
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.bad_page |-> !o_data.page_fault && !o_data.replaced)
        else $error("bad page changed table");
    a_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.replaced |-> o_data.page_fault) else $error("evict on hit");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.frames_in_use <= 6'd32) else $error("frame count");
endmodule
bind page_table_lru_translate ptlru_check u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid),
    .i_stall(i_stall), .o_data(o_data)
);
`default_nettype wire
